// ===== hw/rtl/audio_packet_deframer_gap_counter_core_defines.svh =====
// Assertion macros shared by the audio deframer RTL.
`ifndef AUDIO_PACKET_DEFRAMER_GAP_COUNTER_CORE_DEFINES_SVH
`define AUDIO_PACKET_DEFRAMER_GAP_COUNTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define APDGC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Check that a trigger implies a consequence in the following cycle.
`define APDGC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define APDGC_ASSERT(lbl, clk, rstn, prop)
`define APDGC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hw/rtl/apdgc_pkg.sv =====
// Package with constants and types of the audio deframer.
`timescale 1ns / 1ps
`default_nettype none
package apdgc_pkg;

  localparam int unsigned MAX_DATAGRAM_BYTES = 2048;
  localparam int unsigned MAX_PAIRS          = 512;
  localparam int unsigned HDR_BYTES          = 2;
  localparam int unsigned MIN_ACCEPT_BYTES   = 6;
  localparam int unsigned OUT_TDATA_W        = 96;

  typedef struct packed {
    logic [31:0]        packet_total;
    logic [31:0]        gap_total;
    logic               datagram_done;
    logic               pair_valid;
    logic signed [15:0] right_sample;
    logic signed [15:0] left_sample;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/audio_packet_deframer_gap_counter_core.sv =====
// Throughput: one byte per cycle unless the skid entry is full; all parsing
//   and counter updates happen in the accept cycle, and a two-entry output
//   register/skid stage absorbs stalls and holds each registered result item.
// Reset (rst_ni low, asynchronous) clears the byte position, sequence state,
//   gap total, packet total and the output stage valid flags.
`timescale 1ns / 1ps
`default_nettype none
module audio_packet_deframer_gap_counter_core #(
  parameter int unsigned MaxDatagramBytes = apdgc_pkg::MAX_DATAGRAM_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,   // end_of_datagram
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [15:0] left_sample, [31:16] right_sample, [63:32] gap_total,
  // [95:64] packet_total
  output logic [apdgc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic             m_axis_tuser_o,   // pair_valid
  output logic             m_axis_tlast_o    // datagram_done
);
  import apdgc_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign accept = s_axis_tvalid_i & s_axis_tready_o;

  apdgc_frame #(
    .MaxDatagramBytes(MaxDatagramBytes)
  ) u_frame (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .data_byte_i       (s_axis_tdata_i),
    .end_of_datagram_i (s_axis_tlast_i),
    .res_valid_o       (res_valid),
    .res_o             (res)
  );

  apdgc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {out_res.packet_total, out_res.gap_total,
                           out_res.right_sample, out_res.left_sample};
  assign m_axis_tuser_o = out_res.pair_valid;
  assign m_axis_tlast_o = out_res.datagram_done;

endmodule
`default_nettype wire

// ===== hw/rtl/apdgc_frame.sv =====
// Byte parser, sample pair assembly and sequence gap / packet counters.
`timescale 1ns / 1ps
`default_nettype none
`include "audio_packet_deframer_gap_counter_core_defines.svh"
module apdgc_frame #(
  parameter int unsigned MaxDatagramBytes = apdgc_pkg::MAX_DATAGRAM_BYTES
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            end_of_datagram_i,
  output logic                 res_valid_o,
  output apdgc_pkg::result_t   res_o
);
  import apdgc_pkg::*;

  localparam int unsigned PosW = $clog2(MaxDatagramBytes + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MaxDatagramBytes);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     seq_q, seq_d;
  logic [15:0]     prev_q, prev_d;
  logic [23:0]     part_q, part_d;
  logic [31:0]     gap_q, gap_d;
  logic [31:0]     pkt_q, pkt_d;

  logic [PosW-1:0] q_off;
  logic [15:0]     seq_upd;
  logic [15:0]     gap_calc;
  logic [32:0]     gap_sum;
  logic            pair;

  always_comb begin
    pos_d    = pos_q;
    seq_upd  = seq_q;
    prev_d   = prev_q;
    part_d   = part_q;
    gap_d    = gap_q;
    pkt_d    = pkt_q;
    pair     = 1'b0;
    q_off    = pos_q - PosW'(HDR_BYTES);

    // Drop bytes past the maximum datagram length.
    if (pos_q < PosMax) begin
      pos_d = pos_q + PosW'(1);
      if (pos_q == '0) begin
        seq_upd = {8'h00, data_byte_i};
      end else if (pos_q == PosW'(1)) begin
        seq_upd = {data_byte_i, seq_q[7:0]};
      end else begin
        case (q_off[1:0])
          2'd0: part_d = {16'h0000, data_byte_i};
          2'd1: part_d[15:8] = data_byte_i;
          2'd2: part_d[23:16] = data_byte_i;
          default: begin
            if (32'(q_off >> 2) < MAX_PAIRS) begin
              pair = 1'b1;
            end
          end
        endcase
      end
    end

    seq_d    = seq_upd;
    gap_calc = seq_upd - prev_q - 16'd1;
    gap_sum  = {1'b0, gap_q} + {17'b0, gap_calc};

    if (end_of_datagram_i) begin
      if (pos_d >= PosW'(MIN_ACCEPT_BYTES)) begin
        // Count only forward gaps, and only once a nonzero sequence was seen.
        if (prev_q != 16'h0000 && !gap_calc[15]) begin
          gap_d = gap_sum[32] ? 32'hFFFF_FFFF : gap_sum[31:0];
        end
        prev_d = seq_upd;
        if (pkt_q != 32'hFFFF_FFFF) begin
          pkt_d = pkt_q + 32'd1;
        end
      end
      pos_d  = '0;
      seq_d  = '0;
      part_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      seq_q  <= '0;
      prev_q <= '0;
      part_q <= '0;
      gap_q  <= '0;
      pkt_q  <= '0;
    end else if (accept_i) begin
      pos_q  <= pos_d;
      seq_q  <= seq_d;
      prev_q <= prev_d;
      part_q <= part_d;
      gap_q  <= gap_d;
      pkt_q  <= pkt_d;
    end
  end

  always_comb begin
    res_valid_o          = accept_i & (pair | end_of_datagram_i);
    res_o.left_sample    = pair ? part_q[15:0] : 16'h0000;
    res_o.right_sample   = pair ? {data_byte_i, part_q[23:16]} : 16'h0000;
    res_o.pair_valid     = pair;
    res_o.datagram_done  = end_of_datagram_i;
    res_o.gap_total      = gap_d;
    res_o.packet_total   = pkt_d;
  end

  `APDGC_ASSERT(a_pos_bound, clk_i, rst_ni, pos_q <= PosMax)
  `APDGC_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, accept_i && end_of_datagram_i,
                     pos_q == '0 && seq_q == 16'h0000 && part_q == 24'h000000)
  `APDGC_ASSERT_NEXT(a_pkt_monotone, clk_i, rst_ni, 1'b1, pkt_q >= $past(pkt_q))

endmodule
`default_nettype wire

// ===== hw/rtl/apdgc_out_buf.sv =====
// Output register with skid stage for result items.
`timescale 1ns / 1ps
`default_nettype none
`include "audio_packet_deframer_gap_counter_core_defines.svh"
module apdgc_out_buf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire apdgc_pkg::result_t  push_data_i,
  output logic                     ready_o,
  output logic                     out_valid_o,
  output apdgc_pkg::result_t       out_data_o,
  input  wire logic                out_ready_i
);
  import apdgc_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop     = out_valid_q & out_ready_i;
  assign ready_o = ~skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // Advance the skid item once the output slot frees.
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `APDGC_ASSERT(a_skid_needs_out, clk_i, rst_ni, !skid_valid_q || out_valid_q)
  `APDGC_ASSERT(a_no_push_full, clk_i, rst_ni, !(push_i && skid_valid_q))
  `APDGC_ASSERT_NEXT(a_hold_unpopped, clk_i, rst_ni, out_valid_q && !out_ready_i,
                     out_valid_q && out_q == $past(out_q))

endmodule
`default_nettype wire
